// ----- hdl/substring_find_count_scanner_defines.svh -----
// ---------------------------------------------------------------------------
// Substring scanner assertion macros
// Shared concurrent check wrappers; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef SUBSTRING_FIND_COUNT_SCANNER_DEFINES_SVH
`define SUBSTRING_FIND_COUNT_SCANNER_DEFINES_SVH

`ifndef SYNTHESIS
// Check outside reset, on clk
`define SSC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("substring scanner check failed");
// Check at every edge, reset included
`define SSC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("substring scanner reset check failed");
`else
`define SSC_ASSERT(label, prop)
`define SSC_ASSERT_RST(label, prop)
`endif

`endif

// ----- hdl/ssc_pkg.sv -----
// ---------------------------------------------------------------------------
// Substring scanner package
// Widths, register map codes, shared types and the pattern byte select.
// ---------------------------------------------------------------------------
package ssc_pkg;

  localparam int MAX_PAT = 16;                 // pattern bytes, window cells
  localparam int PIDX_W  = $clog2(MAX_PAT);    // pattern byte index
  localparam int LEN_W   = $clog2(MAX_PAT) + 1; // length, holds MAX_PAT
  localparam int IDX_W   = 16;                 // byte position
  localparam int POS_W   = IDX_W + 1;          // signed match position
  localparam int CNT_W   = 16;                 // match count
  localparam int DW      = 64;                 // config data width
  localparam int AW      = 6;                  // config address width
  localparam int RSEL_W  = 3;                  // register select, paddr[5:3]
  localparam int OUT_PAY_W  = 2 * POS_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8;

  // register select codes
  localparam logic [RSEL_W-1:0] REG_PAT_LO  = 3'd0;
  localparam logic [RSEL_W-1:0] REG_PAT_HI  = 3'd1;
  localparam logic [RSEL_W-1:0] REG_PAT_LEN = 3'd2;
  localparam logic [RSEL_W-1:0] REG_FIRST   = 3'd3;
  localparam logic [RSEL_W-1:0] REG_FINAL   = 3'd4;
  localparam logic [RSEL_W-1:0] REG_TO_END  = 3'd5;

  typedef struct packed {
    logic [8*MAX_PAT-1:0] pattern;    // byte 0 in bits 7:0
    logic [LEN_W-1:0]     len;        // clamped to MAX_PAT
    logic [IDX_W-1:0]     range_first;
    logic [IDX_W-1:0]     range_final;
    logic                 to_end;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] first_position;
    logic [POS_W-1:0] final_position;
    logic [CNT_W-1:0] match_total;
    logic             range_valid;
  } result_t;

  // select one pattern byte
  function automatic logic [7:0] pat_byte(input logic [8*MAX_PAT-1:0] pattern,
                                          input logic [PIDX_W-1:0] idx);
    return pattern[8*idx +: 8];
  endfunction

endpackage

// ----- hdl/ssc_cell.sv -----
// ---------------------------------------------------------------------------
// Substring scanner window cell
// Holds one window byte, shifts it on, compares the incoming byte.
// ---------------------------------------------------------------------------
module ssc_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] byte_in,
  input  logic [7:0] pat_byte_in,
  input  logic       cmp_en,
  output logic [7:0] byte_out,
  output logic       cmp_ok
);
  import ssc_pkg::*;

  logic [7:0] byte_r;

  // advance the window on each accepted beat
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

  // compare the byte that lands here this beat
  assign cmp_ok = !cmp_en || (byte_in == pat_byte_in);

endmodule

// ----- hdl/ssc_cfg.sv -----
// ---------------------------------------------------------------------------
// Substring scanner register file
// APB-style registers for the pattern and the search range.
// ---------------------------------------------------------------------------
module ssc_cfg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ssc_pkg::AW-1:0] paddr,
  input  logic [ssc_pkg::DW-1:0] pwdata,
  output logic [ssc_pkg::DW-1:0] prdata,
  output logic                   pready,
  output ssc_pkg::cfg_t          cfg
);
  import ssc_pkg::*;

  logic [DW-1:0]     pat_lo_r;
  logic [DW-1:0]     pat_hi_r;
  logic [LEN_W-1:0]  pat_len_r;
  logic [IDX_W-1:0]  first_r;
  logic [IDX_W-1:0]  final_r;
  logic              to_end_r;
  logic              wr_en;
  logic [RSEL_W-1:0] rsel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign rsel   = paddr[AW-1:AW-RSEL_W];

  // write registers on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      pat_len_r <= '0;
      first_r   <= '0;
      final_r   <= '0;
      to_end_r  <= 1'b1;
    end else if (wr_en) begin
      unique case (rsel)
        REG_PAT_LO:  pat_lo_r  <= pwdata;
        REG_PAT_HI:  pat_hi_r  <= pwdata;
        REG_PAT_LEN: pat_len_r <= pwdata[LEN_W-1:0];
        REG_FIRST:   first_r   <= pwdata[IDX_W-1:0];
        REG_FINAL:   final_r   <= pwdata[IDX_W-1:0];
        REG_TO_END:  to_end_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (rsel)
      REG_PAT_LO:  prdata = pat_lo_r;
      REG_PAT_HI:  prdata = pat_hi_r;
      REG_PAT_LEN: prdata = {{(DW-LEN_W){1'b0}}, pat_len_r};
      REG_FIRST:   prdata = {{(DW-IDX_W){1'b0}}, first_r};
      REG_FINAL:   prdata = {{(DW-IDX_W){1'b0}}, final_r};
      REG_TO_END:  prdata = {{(DW-1){1'b0}}, to_end_r};
      default:     prdata = '0;
    endcase
  end

  // clamp the length to the window size
  always_comb begin
    cfg.pattern     = {pat_hi_r, pat_lo_r};
    cfg.len         = (pat_len_r > LEN_W'(MAX_PAT)) ? LEN_W'(MAX_PAT) : pat_len_r;
    cfg.range_first = first_r;
    cfg.range_final = final_r;
    cfg.to_end      = to_end_r;
  end

endmodule

// ----- hdl/ssc_tracker.sv -----
// ---------------------------------------------------------------------------
// Substring scanner match tracker
// Counts positions, records match starts and builds the end-of-string result.
// ---------------------------------------------------------------------------
`include "substring_find_count_scanner_defines.svh"

module ssc_tracker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             beat,
  input  logic             last,
  input  logic             cells_ok,
  input  ssc_pkg::cfg_t    cfg,
  output logic             res_valid,
  output ssc_pkg::result_t res
);
  import ssc_pkg::*;

  logic [IDX_W-1:0] pos_r,  pos_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt, fill_upd;
  logic             left_v_r, left_v_nxt, left_v_upd;
  logic [IDX_W-1:0] left_r, left_nxt, left_upd;
  logic             right_v_r, right_v_nxt, right_v_upd;
  logic [IDX_W-1:0] right_r, right_nxt, right_upd;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_upd;
  logic [IDX_W-1:0] allow_r, allow_nxt, allow_upd;
  logic             hit, in_range, rec;
  logic [IDX_W-1:0] start;
  logic [IDX_W:0]   allow_sum;
  logic             valid;
  logic [IDX_W-1:0] range_end;

  // window fill and match judgment for this byte
  always_comb begin
    fill_upd  = (fill_r == LEN_W'(MAX_PAT)) ? fill_r : fill_r + LEN_W'(1);
    hit       = (cfg.len != '0) && (fill_upd >= cfg.len) && cells_ok;
    start     = pos_r + IDX_W'(1) - IDX_W'(cfg.len);
    in_range  = (start >= cfg.range_first) && (cfg.to_end || pos_r <= cfg.range_final);
    rec       = hit && in_range;
    allow_sum = {1'b0, start} + (IDX_W+1)'(cfg.len);
  end

  // update match records
  always_comb begin
    left_v_upd  = left_v_r;
    left_upd    = left_r;
    right_v_upd = right_v_r;
    right_upd   = right_r;
    cnt_upd     = cnt_r;
    allow_upd   = allow_r;
    if (rec) begin
      if (!left_v_r) begin
        left_v_upd = 1'b1;
        left_upd   = start;
      end
      right_v_upd = 1'b1;
      right_upd   = start;
      if (start >= allow_r) begin
        if (cnt_r != '1) begin
          cnt_upd = cnt_r + CNT_W'(1);
        end
        allow_upd = allow_sum[IDX_W] ? '1 : allow_sum[IDX_W-1:0];
      end
    end
  end

  // range check and result at the final byte
  always_comb begin
    if (cfg.to_end) begin
      range_end = pos_r;
      valid     = cfg.range_first <= pos_r;
    end else begin
      range_end = cfg.range_final;
      valid     = (cfg.range_first <= cfg.range_final) && (cfg.range_final <= pos_r);
    end
    res_valid = beat && last;
    res.range_valid = valid;
    if (!valid) begin
      res.first_position = '1;
      res.final_position = '1;
      res.match_total    = '0;
    end else if (cfg.len == '0) begin
      res.first_position = {1'b0, cfg.range_first};
      res.final_position = {1'b0, range_end};
      res.match_total    = '0;
    end else begin
      res.first_position = left_v_upd  ? {1'b0, left_upd}  : '1;
      res.final_position = right_v_upd ? {1'b0, right_upd} : '1;
      res.match_total    = cnt_upd;
    end
  end

  // advance or clear the scan state
  always_comb begin
    pos_nxt     = pos_r;
    fill_nxt    = fill_r;
    left_v_nxt  = left_v_r;
    left_nxt    = left_r;
    right_v_nxt = right_v_r;
    right_nxt   = right_r;
    cnt_nxt     = cnt_r;
    allow_nxt   = allow_r;
    if (beat) begin
      if (last) begin
        pos_nxt     = '0;
        fill_nxt    = '0;
        left_v_nxt  = 1'b0;
        right_v_nxt = 1'b0;
        cnt_nxt     = '0;
        allow_nxt   = '0;
      end else begin
        pos_nxt     = pos_r + IDX_W'(1);
        fill_nxt    = fill_upd;
        left_v_nxt  = left_v_upd;
        left_nxt    = left_upd;
        right_v_nxt = right_v_upd;
        right_nxt   = right_upd;
        cnt_nxt     = cnt_upd;
        allow_nxt   = allow_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      fill_r    <= '0;
      left_v_r  <= 1'b0;
      right_v_r <= 1'b0;
      cnt_r     <= '0;
      allow_r   <= '0;
    end else begin
      pos_r     <= pos_nxt;
      fill_r    <= fill_nxt;
      left_v_r  <= left_v_nxt;
      right_v_r <= right_v_nxt;
      cnt_r     <= cnt_nxt;
      allow_r   <= allow_nxt;
    end
  end

  // match positions carry no reset
  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    right_r <= right_nxt;
  end

  `SSC_ASSERT(a_count_has_left, (cnt_r != '0) |-> left_v_r)
  `SSC_ASSERT(a_invalid_result, (res_valid && !res.range_valid) |-> (res.first_position == '1 && res.match_total == '0))

endmodule

// ----- hdl/substring_find_count_scanner.sv -----
// ---------------------------------------------------------------------------
// Substring find and count scanner
// Streams a byte string past a configured pattern and reports match stats.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one text byte per beat in in_tdata[7:0]; in_tlast marks the
//           final byte of a string.
//   out_* : one result beat per string, registered when the final byte is
//           accepted (skid stage if held): first and last match start (-1 if
//           none), greedy non-overlapping match count, range_valid in tuser.
//   APB   : pattern bytes, length and search range; write between strings.
// Throughput is one byte per cycle while the skid stage is empty: a row of 16
// window cells shifts the text and compares all pattern bytes against it in
// parallel, and the tracker updates the match records in the same cycle.
// Reset clears the scan state and the output stage; registers return to
// an empty pattern with the range running to the end of the string.
// When the receiver stalls, a skid stage holds a second result; input
// stops only while both the output register and the skid stage are full.
// ---------------------------------------------------------------------------
`include "substring_find_count_scanner_defines.svh"

module substring_find_count_scanner (
  input  logic                            clk,
  input  logic                            rst_n,
  // text_byte [7:0]
  input  logic [7:0]                      in_tdata,
  input  logic                            in_tlast,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // first_position [16:0], final_position [33:17], match_total [49:34], zero pad
  output logic [ssc_pkg::OUT_TDATA_W-1:0] out_tdata,
  // range_valid [0]
  output logic                            out_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ssc_pkg::AW-1:0]          paddr,
  input  logic [ssc_pkg::DW-1:0]          pwdata,
  output logic [ssc_pkg::DW-1:0]          prdata,
  output logic                            pready
);
  import ssc_pkg::*;

  cfg_t       cfg;
  result_t    res;
  logic       res_valid;
  logic       beat;
  logic [7:0] chain [0:MAX_PAT-1];
  logic [MAX_PAT-1:0] cell_ok;

  result_t out_r,  out_nxt;
  result_t skid_r, skid_nxt;
  logic    out_valid_r,  out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  logic    pop;

  ssc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign beat     = in_tvalid && in_tready;
  assign chain[0] = in_tdata;

  // window cells: cell k lines up with pattern byte len-1-k
  for (genvar k = 0; k < MAX_PAT; k++) begin : g_cell
    logic [LEN_W-1:0] pidx;
    logic             en;
    assign pidx = cfg.len - LEN_W'(1) - LEN_W'(k);
    assign en   = LEN_W'(k) < cfg.len;
    if (k < MAX_PAT - 1) begin : g_mid
      ssc_cell u_cell (
        .clk         (clk),
        .shift_en    (beat),
        .byte_in     (chain[k]),
        .pat_byte_in (pat_byte(cfg.pattern, pidx[PIDX_W-1:0])),
        .cmp_en      (en),
        .byte_out    (chain[k+1]),
        .cmp_ok      (cell_ok[k])
      );
    end else begin : g_end
      ssc_cell u_cell (
        .clk         (clk),
        .shift_en    (beat),
        .byte_in     (chain[k]),
        .pat_byte_in (pat_byte(cfg.pattern, pidx[PIDX_W-1:0])),
        .cmp_en      (en),
        .byte_out    (),
        .cmp_ok      (cell_ok[k])
      );
    end
  end

  ssc_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .last      (in_tlast),
    .cells_ok  (&cell_ok),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register plus skid stage
  assign in_tready = !skid_valid_r;
  assign pop       = out_valid_r && out_tready;

  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      if (res_valid) begin
        out_nxt = res;
      end
      out_valid_nxt = res_valid;
    end else if (res_valid) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.range_valid;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_PAY_W){1'b0}},
                       out_r.match_total, out_r.final_position, out_r.first_position};

  `SSC_ASSERT(a_skid_behind_out, skid_valid_r |-> out_valid_r)
  `SSC_ASSERT(a_skid_drains, (skid_valid_r && out_tready) |=> (out_valid_r && !skid_valid_r))
  `SSC_ASSERT_RST(a_reset_empties, !rst_n |=> (!out_valid_r && !skid_valid_r))

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Substring scanner testbench
// Streams text strings into the scanner and checks every per-string report
// (first and last match start, greedy match count, range valid) against an
// in-bench scan model or a table entry. Starts with a directed table, then runs
// randomized setup phases with random gaps on both streams and a long receiver hold.
// ---------------------------------------------------------------------------
module tb_top;
  import ssc_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_BYTES = 480;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_B = 8'h62;

  typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [RSEL_W-1:0] sel;
    logic [DW-1:0]     value;
    logic [7:0]        data;
    logic              last;
    bit                known;
    result_t           report;
  } dir_row_t;

  logic                   clk;
  logic                   rst_n;
  logic [7:0]             in_tdata;
  logic                   in_tlast;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [AW-1:0]          paddr;
  logic [DW-1:0]          pwdata;
  logic [DW-1:0]          prdata;
  logic                   pready;

  // scan model: register copy
  logic [8*MAX_PAT-1:0] cfg_pattern;
  logic [4:0]           cfg_len;
  logic [IDX_W-1:0]     cfg_first;
  logic [IDX_W-1:0]     cfg_final;
  logic                 cfg_to_end;

  // scan model: per-string state
  logic [7:0]       win [MAX_PAT];
  logic [IDX_W-1:0] scan_pos;
  int               first_hit;
  int               last_hit;
  int               hit_count;
  int               next_start;
  int               win_fill;

  result_t expected_reports[$];

  // stimulus shaping
  logic [8*MAX_PAT-1:0] cur_pattern;
  int                   eff_len;
  bit                   full_mode;
  bit                   src_gappy;
  int                   hold_request;

  int fail_count;
  int reports_checked;
  int bytes_sent;
  int random_bytes;
  int reg_writes;
  int quiet_cycles;

  substring_find_count_scanner uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic void clear_scan_state();
    int k;
    for (k = 0; k < MAX_PAT; k++) win[k] = 8'h00;
    scan_pos   = '0;
    first_hit  = -1;
    last_hit   = -1;
    hit_count  = 0;
    next_start = 0;
    win_fill   = 0;
  endfunction

  // advance the scan by one text byte; return 1 with the report on the last byte
  function automatic bit scan_text_byte(input logic [7:0] b, input logic last,
                                        output result_t rep);
    int len, p, s, k, rend;
    bit hit, valid;
    rep = '0;
    p   = int'(scan_pos);
    len = (cfg_len > MAX_PAT) ? MAX_PAT : int'(cfg_len);
    for (k = MAX_PAT - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = b;
    if (win_fill < MAX_PAT) win_fill++;
    if (len > 0 && win_fill >= len) begin
      hit = 1'b1;
      for (k = 0; k < len; k++)
        if (cfg_pattern[8*k +: 8] != win[len-1-k]) hit = 1'b0;
      if (hit) begin
        s = (p - len + 1) & 'hFFFF;
        if (s >= cfg_first && (cfg_to_end || p <= cfg_final)) begin
          if (first_hit < 0) first_hit = s;
          last_hit = s;
          // greedy count: skip matches that overlap the last counted one
          if (s >= next_start) begin
            if (hit_count < 'hFFFF) hit_count++;
            next_start = (s + len > 'hFFFF) ? 'hFFFF : s + len;
          end
        end
      end
    end
    scan_pos = scan_pos + 1'b1;
    if (!last) return 1'b0;

    if (cfg_to_end) begin
      rend  = p;
      valid = cfg_first <= p;
    end else begin
      rend  = cfg_final;
      valid = (cfg_first <= cfg_final) && (cfg_final <= p);
    end
    if (!valid) begin
      rep.first_position = '1;
      rep.final_position = '1;
    end else if (len == 0) begin
      rep.first_position = POS_W'(cfg_first);
      rep.final_position = POS_W'(rend);
    end else begin
      rep.first_position = POS_W'(first_hit);
      rep.final_position = POS_W'(last_hit);
      rep.match_total    = CNT_W'(hit_count);
    end
    rep.range_valid = valid;
    clear_scan_state();
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!src_gappy) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] filler_byte();
    int idx;
    idx = (eff_len > 0) ? $urandom_range(0, eff_len - 1) : 0;
    if (full_mode) begin
      if (eff_len > 0 && $urandom_range(0, 1) == 1) return cur_pattern[8*idx +: 8];
      return 8'($urandom);
    end
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return CH_A + 8'($urandom_range(0, 2));
  endfunction

  function automatic dir_row_t cfg_row(input logic [RSEL_W-1:0] sel, input logic [DW-1:0] v);
    dir_row_t row;
    row       = '{ROW_CFG, sel, v, 8'h00, 1'b0, 1'b0, '0};
    return row;
  endfunction

  function automatic dir_row_t beat_row(input logic [7:0] b, input logic last);
    dir_row_t row;
    row       = '{ROW_BEAT, REG_PAT_LO, '0, b, last, 1'b0, '0};
    return row;
  endfunction

  // last byte of a string whose report is obvious by inspection
  function automatic dir_row_t known_row(input logic [7:0] b, input logic [POS_W-1:0] f,
                                         input logic [POS_W-1:0] l,
                                         input logic [CNT_W-1:0] n, input logic vld);
    dir_row_t row;
    row        = '{ROW_BEAT, REG_PAT_LO, '0, b, 1'b1, 1'b1, '0};
    row.report = '{f, l, n, vld};
    return row;
  endfunction

  task automatic flag_failure(input string msg);
    if (fail_count < 10) $display("tb_top: MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // two-phase register write; the model copy changes at the access edge
  task automatic write_reg(input logic [RSEL_W-1:0] sel, input logic [DW-1:0] v);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 3'b000};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (sel)
      REG_PAT_LO:  cfg_pattern[63:0]   = v;
      REG_PAT_HI:  cfg_pattern[127:64] = v;
      REG_PAT_LEN: cfg_len             = v[4:0];
      REG_FIRST:   cfg_first           = v[15:0];
      REG_FINAL:   cfg_final           = v[15:0];
      REG_TO_END:  cfg_to_end          = v[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // offer one text beat, hold it until taken, then predict
  task automatic send_byte(input logic [7:0] b, input logic last, input bit known,
                           input result_t known_rep);
    int gap;
    bit has;
    result_t rep;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    has = scan_text_byte(b, last, rep);
    if (has) expected_reports.push_back(known ? known_rep : rep);
    bytes_sent++;
  endtask

  // stop offering and wait for every report to come back
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_random_setup(input int phase);
    int r, len;
    int k;
    logic [8*MAX_PAT-1:0] pat;
    logic [IDX_W-1:0] first, fin;
    r   = $urandom_range(0, 99);
    len = (r < 5) ? 0 : (r < 55) ? $urandom_range(1, 4) :
          (r < 90) ? $urandom_range(5, 16) : $urandom_range(17, 31);
    r     = $urandom_range(0, 99);
    first = (r < 60) ? 16'd0 : (r < 85) ? 16'($urandom_range(1, 8)) :
            (r < 93) ? 16'hFFFF : 16'($urandom);
    r     = $urandom_range(0, 99);
    fin   = (r < 10) ? 16'd0 : (r < 75) ? 16'($urandom_range(2, 40)) :
            (r < 85) ? 16'hFFFF : 16'($urandom);
    // pin a full-length pattern and the top of the index range once each
    if (phase == 0) len = 16;
    if (phase == 3) begin
      first = 16'hFFFF;
      fin   = 16'hFFFF;
    end
    full_mode = ($urandom_range(0, 3) == 0);
    pat = {$urandom, $urandom, $urandom, $urandom};
    if (!full_mode)
      for (k = 0; k < MAX_PAT; k++) pat[8*k +: 8] = CH_A + 8'($urandom_range(0, 2));
    cur_pattern = pat;
    eff_len     = (len > MAX_PAT) ? MAX_PAT : len;
    write_reg(REG_PAT_LO, pat[63:0]);
    write_reg(REG_PAT_HI, pat[127:64]);
    write_reg(REG_PAT_LEN, DW'(len));
    write_reg(REG_FIRST, DW'(first));
    write_reg(REG_FINAL, DW'(fin));
    write_reg(REG_TO_END, DW'($urandom_range(0, 1)));
  endtask

  // receiver: random ready with quiet stretches, plus requested long holds
  initial begin
    int off, streak, seen;
    bit gappy;
    out_tready = 1'b0;
    off        = 0;
    streak     = 0;
    seen       = 0;
    gappy      = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_request != seen) begin
        off  = HOLD_CYCLES;
        seen = hold_request;
      end
      if (streak == 0) begin
        gappy  = ($urandom_range(0, 2) != 0);
        streak = $urandom_range(20, 120);
      end
      streak--;
      if (off > 0) begin
        out_tready = 1'b0;
        off--;
      end else if (gappy && $urandom_range(0, 9) < 3) begin
        off        = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
                     $urandom_range(0, 2);
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // compare each report beat with the oldest prediction
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.first_position = out_tdata[16:0];
      got.final_position = out_tdata[33:17];
      got.match_total    = out_tdata[49:34];
      got.range_valid    = out_tuser;
      if (expected_reports.size() == 0) begin
        flag_failure($sformatf("unexpected report %p", got));
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        if (got.first_position !== want.first_position)
          flag_failure($sformatf("first_position exp %0h got %0h",
                                 want.first_position, got.first_position));
        if (got.final_position !== want.final_position)
          flag_failure($sformatf("final_position exp %0h got %0h",
                                 want.final_position, got.final_position));
        if (got.match_total !== want.match_total)
          flag_failure($sformatf("match_total exp %0d got %0d",
                                 want.match_total, got.match_total));
        if (got.range_valid !== want.range_valid)
          flag_failure($sformatf("range_valid exp %0b got %0b",
                                 want.range_valid, got.range_valid));
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top: watchdog expired, %0d reports outstanding",
                 expected_reports.size());
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t tab[$];
    logic [7:0] txt[$];
    result_t none;
    int phase, nstr, tlen, i, j;

    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = 8'h00;
    in_tlast     = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    none         = '0;
    src_gappy    = 1'b1;
    hold_request = 0;
    fail_count   = 0;
    reports_checked = 0;
    bytes_sent   = 0;
    random_bytes = 0;
    reg_writes   = 0;
    cur_pattern  = '0;
    eff_len      = 0;
    full_mode    = 1'b0;
    cfg_pattern  = '0;
    cfg_len      = '0;
    cfg_first    = '0;
    cfg_final    = '0;
    cfg_to_end   = 1'b1;
    clear_scan_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty pattern after reset, greedy overlap, ranged mode,
    // invalid ranges, oversized length
    tab.push_back(known_row(8'h00, 17'd0, 17'd0, 16'd0, 1'b1));
    tab.push_back(beat_row(8'hFF, 1'b0));
    tab.push_back(known_row(8'h00, 17'd0, 17'd1, 16'd0, 1'b1));
    tab.push_back(cfg_row(REG_PAT_LO, 64'h0000_0000_0061_6261));
    tab.push_back(cfg_row(REG_PAT_LEN, 64'd3));
    tab.push_back(beat_row(CH_A, 1'b0));
    tab.push_back(beat_row(CH_B, 1'b0));
    tab.push_back(beat_row(CH_A, 1'b0));
    tab.push_back(beat_row(CH_B, 1'b0));
    tab.push_back(beat_row(CH_A, 1'b1));
    tab.push_back(cfg_row(REG_FIRST, 64'd1));
    tab.push_back(known_row(8'hFF, 17'h1FFFF, 17'h1FFFF, 16'd0, 1'b0));
    tab.push_back(cfg_row(REG_FIRST, 64'd0));
    tab.push_back(cfg_row(REG_TO_END, 64'd0));
    tab.push_back(cfg_row(REG_FINAL, 64'd3));
    tab.push_back(beat_row(CH_A, 1'b0));
    tab.push_back(beat_row(CH_B, 1'b0));
    tab.push_back(beat_row(CH_A, 1'b0));
    tab.push_back(beat_row(CH_B, 1'b0));
    tab.push_back(beat_row(CH_A, 1'b1));
    tab.push_back(beat_row(CH_A, 1'b0));
    tab.push_back(known_row(CH_B, 17'h1FFFF, 17'h1FFFF, 16'd0, 1'b0));
    tab.push_back(cfg_row(REG_PAT_HI, 64'hFFFF_FFFF_FFFF_FFFF));
    tab.push_back(cfg_row(REG_PAT_LEN, 64'd31));
    tab.push_back(cfg_row(REG_TO_END, 64'd1));
    tab.push_back(beat_row(8'h00, 1'b1));

    foreach (tab[i]) begin
      if (tab[i].kind == ROW_CFG) begin
        settle();
        write_reg(tab[i].sel, tab[i].value);
      end else begin
        send_byte(tab[i].data, tab[i].last, tab[i].known, tab[i].report);
      end
    end

    // random setups, each followed by a batch of strings
    phase = 0;
    while (random_bytes < RANDOM_BYTES) begin
      settle();
      load_random_setup(phase);
      src_gappy = ($urandom_range(0, 3) != 0);
      if (phase == 1) begin
        // hold the receiver while one-byte strings keep coming
        src_gappy = 1'b0;
        hold_request++;
        for (i = 0; i < 12; i++) send_byte(8'($urandom), 1'b1, 1'b0, none);
        random_bytes += 12;
      end else begin
        nstr = $urandom_range(2, 6);
        for (i = 0; i < nstr; i++) begin
          txt.delete();
          tlen = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24) :
                 $urandom_range(25, 60);
          if ($urandom_range(0, 99) < 15) begin
            while (txt.size() < tlen) txt.push_back(8'($urandom));
          end else begin
            while (txt.size() < tlen) begin
              if (eff_len > 0 && $urandom_range(0, 2) == 0) begin
                for (j = 0; j < eff_len; j++) txt.push_back(cur_pattern[8*j +: 8]);
                // sometimes break the copy
                if ($urandom_range(0, 3) == 0)
                  txt[txt.size() - 1 - $urandom_range(0, eff_len - 1)] = 8'($urandom);
              end else begin
                txt.push_back(filler_byte());
              end
            end
          end
          for (j = 0; j < txt.size(); j++)
            send_byte(txt[j], j == txt.size() - 1, 1'b0, none);
          random_bytes += txt.size();
        end
      end
      phase++;
    end

    settle();
    repeat (8) @(posedge clk);
    if (expected_reports.size() != 0)
      flag_failure($sformatf("%0d reports never arrived", expected_reports.size()));
    $display("tb_top: %0d text bytes, %0d string reports checked, %0d register writes",
             bytes_sent, reports_checked, reg_writes);
    $display("tb_top: %0d random setups and a %0d-cycle receiver hold",
             phase, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
